### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Field widths of one operation and one result
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_OCC_W  = 5;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 16;

  // Operation selector carried in tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Home slot unit: key modulo TABLE_SIZE. A power-of-two size is a registered
// mask; any other size multiplies by a fixed-point reciprocal into a registered
// product, then multiplies the quotient back and subtracts into the remainder.
// ----------------------------------------------------------------------------
module lpht_mod #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int  SLOT_W  = $clog2(TABLE_SIZE);
  localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  if (IS_POW2) begin : g_mask
    // Low key bits are the remainder
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        rem <= key[SLOT_W-1:0];
      end
    end
  end else begin : g_recip
    // Quotient is (key * ceil(2^SHIFT / size)) >> SHIFT; exact for every
    // 31-bit key since the rounding error times the key stays below 2^SHIFT.
    // The reciprocal fits in 32 bits for any size that is not a power of two.
    localparam int              SHIFT   = lpht_pkg::KEY_W + SLOT_W;
    localparam int              PROD_W  = lpht_pkg::KEY_W + 32;
    localparam longint unsigned RECIP   =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [31:0]     RECIP_C = 32'(RECIP);

    logic                       busy;
    logic [lpht_pkg::KEY_W-1:0] key_r;
    logic [PROD_W-1:0]          prod;
    logic [lpht_pkg::KEY_W-1:0] quot;
    logic [lpht_pkg::KEY_W-1:0] back;
    logic [lpht_pkg::KEY_W-1:0] diff;

    // From the registered product: multiply the quotient back and take the difference
    always_comb begin
      quot = lpht_pkg::KEY_W'(prod[PROD_W-1:SHIFT]);
      back = lpht_pkg::KEY_W'(quot * lpht_pkg::KEY_W'(TABLE_SIZE));
      diff = key_r - back;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        done <= 1'b0;
      end else begin
        busy <= start;
        done <= busy;
      end
      // Datapath
      if (start) begin
        key_r <= key;
        prod  <= key * RECIP_C;
      end
      if (busy) begin
        rem <= diff[SLOT_W-1:0];
      end
    end
  end

endmodule

### rtl/linear_probe_hash_table.sv
// Flow: an accepted operation passes S_HASH (home slot from the remainder unit,
// a mask for a power-of-two TABLE_SIZE, a reciprocal otherwise), S_PROBE (an insert
// probes up to TABLE_SIZE slots, a search reads up to TABLE_SIZE through the
// registered key RAM) and S_EMIT. Throughput: one operation at a time, as s_tready
// is low outside S_IDLE; a stalled result beat holds the table in S_EMIT.
// Reset: synchronous, clears the valid bits, occupied count and control state;
// the key and value RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing, one slot per cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Operation stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lpht_pkg::S_TDATA_W-1:0]    s_tdata,  // key[30:0], value[62:31]
  input  logic                              s_tuser,  // func[0]
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lpht_pkg::M_TDATA_W-1:0]    m_tdata   // status[1:0], slot[5:2],
                                                      // occupied[10:6]
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W  = lpht_pkg::KEY_W;
  localparam int VAL_W  = lpht_pkg::VAL_W;

  lpht_pkg::state_t  state;
  lpht_pkg::status_t res_status;
  logic              op_func;
  logic [KEY_W-1:0]  op_key;
  logic [VAL_W-1:0]  op_value;
  logic [SLOT_W-1:0] ptr;
  logic [SLOT_W-1:0] ptr_inc;
  logic [CNT_W-1:0]  steps;
  logic [TABLE_SIZE-1:0] valid;
  logic [CNT_W-1:0]  fill;
  logic [SLOT_W-1:0] res_slot;
  logic              cmp_vld;
  logic              cmp_last;
  logic [SLOT_W-1:0] cmp_slot;
  logic [KEY_W-1:0]  rd_key;
  logic              accept;
  logic              mod_done;
  logic [SLOT_W-1:0] home;
  logic              wr_en;
  logic              issue;
  logic              hit;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == lpht_pkg::S_IDLE);

  // Home slot unit
  lpht_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (s_tdata[KEY_W-1:0]),
    .done  (mod_done),
    .rem   (home)
  );

  // Probe pointer step with wrap-around
  assign ptr_inc = (ptr == SLOT_W'(TABLE_SIZE - 1)) ? '0 : ptr + 1'b1;

  // Insert writes at the first free slot met
  assign wr_en = (state == lpht_pkg::S_PROBE) && (op_func == lpht_pkg::FUNC_INSERT)
                 && !valid[ptr];

  // Search issues one read per cycle until a hit or until every slot has been read
  assign issue = (state == lpht_pkg::S_PROBE) && (op_func == lpht_pkg::FUNC_SEARCH)
                 && (steps != CNT_W'(TABLE_SIZE));
  assign hit   = cmp_vld && valid[cmp_slot] && (rd_key == op_key);

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (op_key),
    .rd_addr (ptr),
    .rd_data (rd_key)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_values (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (op_value),
    .rd_addr (ptr),
    .rd_data ()
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpht_pkg::S_IDLE;
      valid    <= '0;
      fill     <= '0;
      cmp_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Result valid: set as the result loads, cleared when the beat leaves
      if (state == lpht_pkg::S_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        lpht_pkg::S_IDLE: begin
          cmp_vld <= 1'b0;
          if (accept) begin
            state <= lpht_pkg::S_HASH;
          end
        end
        lpht_pkg::S_HASH: begin
          if (mod_done) begin
            state <= lpht_pkg::S_PROBE;
          end
        end
        lpht_pkg::S_PROBE: begin
          if (op_func == lpht_pkg::FUNC_INSERT) begin
            if (!valid[ptr]) begin
              valid[ptr] <= 1'b1;
              fill       <= fill + 1'b1;
              state      <= lpht_pkg::S_EMIT;
            end else if (steps == CNT_W'(TABLE_SIZE - 1)) begin
              state <= lpht_pkg::S_EMIT;
            end
          end else begin
            cmp_vld <= issue;
            if (hit || (cmp_vld && cmp_last)) begin
              state <= lpht_pkg::S_EMIT;
            end
          end
        end
        lpht_pkg::S_EMIT: begin
          cmp_vld <= 1'b0;
          if (!m_tvalid || m_tready) begin
            state <= lpht_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lpht_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Operation, probe and result datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= s_tuser;
      op_key   <= s_tdata[KEY_W-1:0];
      op_value <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (state == lpht_pkg::S_HASH && mod_done) begin
      ptr   <= home;
      steps <= '0;
    end else if (state == lpht_pkg::S_PROBE) begin
      if (op_func == lpht_pkg::FUNC_INSERT) begin
        ptr   <= ptr_inc;
        steps <= steps + 1'b1;
        if (!valid[ptr]) begin
          res_status <= lpht_pkg::ST_STORED;
          res_slot   <= ptr;
        end else begin
          res_status <= lpht_pkg::ST_FULL;
          res_slot   <= '0;
        end
      end else begin
        if (issue) begin
          ptr      <= ptr_inc;
          steps    <= steps + 1'b1;
          cmp_slot <= ptr;
          cmp_last <= (steps == CNT_W'(TABLE_SIZE - 1));
        end
        if (hit) begin
          res_status <= lpht_pkg::ST_FOUND;
          res_slot   <= cmp_slot;
        end else begin
          res_status <= lpht_pkg::ST_MISSING;
          res_slot   <= '0;
        end
      end
    end
    // Output register
    if (state == lpht_pkg::S_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'b0, lpht_pkg::OUT_OCC_W'(fill), lpht_pkg::OUT_SLOT_W'(res_slot),
                  res_status};
    end
  end

  // Occupied count tracks the valid bits
  a_fill_matches: assert property (@(posedge clk) disable iff (rst)
    fill == CNT_W'($countones(valid)))
    else $error("occupied count disagrees with valid bits");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_SIZE))
    else $error("occupied count above table size");

  // A full report only when every slot is taken
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::S_EMIT && res_status == lpht_pkg::ST_FULL)
    |-> fill == CNT_W'(TABLE_SIZE))
    else $error("insert dropped with free slots left");

  // A found or stored slot is occupied
  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::S_EMIT &&
     (res_status == lpht_pkg::ST_FOUND || res_status == lpht_pkg::ST_STORED))
    |-> valid[res_slot])
    else $error("reported slot is not occupied");

endmodule

### tb/sv/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the operation and result streams of the hash table, keeps its own
// copy of the table contents, predicts each result beat and compares it.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,    // key[30:0], value[62:31]
  input  logic                 s_tuser,    // func[0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,    // status[1:0], slot[5:2], occupied[10:6]
  output int                   errors,
  output int                   outstanding,
  output int                   n_stored,
  output int                   n_full,
  output int                   n_found,
  output int                   n_missing
);

  typedef struct packed {
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [OUT_OCC_W-1:0]  occupied;
  } table_result_t;

  // Shadow copy of the table
  logic [KEY_W-1:0] shadow_key [TABLE_SIZE];
  logic [VAL_W-1:0] shadow_val [TABLE_SIZE];
  logic             shadow_used[TABLE_SIZE];
  int               shadow_fill;

  table_result_t    expected_results[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    n_stored    = 0;
    n_full      = 0;
    n_found     = 0;
    n_missing   = 0;
    shadow_fill = 0;
    for (int i = 0; i < TABLE_SIZE; i++) shadow_used[i] = 1'b0;
  end

  // Apply one operation to the shadow table and return the result it gives
  function automatic table_result_t probe_table(input logic func,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value);
    table_result_t res;
    int            home;
    int            s;
    logic          done;
    home       = int'(key % TABLE_SIZE);
    res.status = (func == FUNC_INSERT) ? ST_FULL : ST_MISSING;
    res.slot   = '0;
    done       = 1'b0;
    for (int n = 0; n < TABLE_SIZE && !done; n++) begin
      s = (home + n) % TABLE_SIZE;
      if (func == FUNC_INSERT) begin
        if (!shadow_used[s]) begin
          shadow_key[s]  = key;
          shadow_val[s]  = value;
          shadow_used[s] = 1'b1;
          shadow_fill++;
          res.status = ST_STORED;
          res.slot   = OUT_SLOT_W'(s);
          done       = 1'b1;
        end
      end else if (shadow_used[s] && shadow_key[s] == key) begin
        res.status = ST_FOUND;
        res.slot   = OUT_SLOT_W'(s);
        done       = 1'b1;
      end
    end
    res.occupied = OUT_OCC_W'(shadow_fill);
    return res;
  endfunction

  // Compare result beats first, then record the prediction for a new operation
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) shadow_used[i] = 1'b0;
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status   = status_t'(m_tdata[STATUS_W-1:0]);
        got.slot     = m_tdata[STATUS_W +: OUT_SLOT_W];
        got.occupied = m_tdata[STATUS_W+OUT_SLOT_W +: OUT_OCC_W];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat status=%0d slot=%0d occupied=%0d",
                   $time, got.status, got.slot, got.occupied);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.occupied !== want.occupied) begin
            errors++;
            $display("%0t: result mismatch expected status=%0d slot=%0d occupied=%0d, got status=%0d slot=%0d occupied=%0d",
                     $time, want.status, want.slot, want.occupied,
                     got.status, got.slot, got.occupied);
          end
          case (want.status)
            ST_STORED:  n_stored++;
            ST_FULL:    n_full++;
            ST_FOUND:   n_found++;
            ST_MISSING: n_missing++;
            default: ;
          endcase
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(probe_table(s_tuser, s_tdata[KEY_W-1:0],
                                               s_tdata[KEY_W +: VAL_W]));
    end
    outstanding = expected_results.size();
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives inserts and searches into the linear-probing hash table under
// several idle and stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import lpht_pkg::*;

  localparam int TABLE_SIZE       = 16;
  localparam int IDLE_LIMIT       = 2000;
  localparam int TAIL_CYCLES      = 40;
  localparam int OPS_PER_PHASE    = 150;
  localparam int INSERT_PCT       = 12;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // key[30:0], value[62:31]
  logic                 s_tuser  = 1'b0; // func[0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // status[1:0], slot[5:2], occupied[10:6]

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;
  int errors, outstanding, n_stored, n_full, n_found, n_missing;

  // Keys sent as inserts, used to aim searches and collisions
  logic [KEY_W-1:0] inserted_keys[$];

  always #5 clk = ~clk;

  linear_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lpht_checker #(.TABLE_SIZE(TABLE_SIZE)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding),
    .n_stored    (n_stored),
    .n_full      (n_full),
    .n_found     (n_found),
    .n_missing   (n_missing)
  );

  // Result-side backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: too long without any beat on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("[linear_probe_hash_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One operation beat, with random gaps ahead of it
  task automatic send_op(input logic func, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (func == FUNC_INSERT) inserted_keys.push_back(key);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return KEY_MAX;
    return KEY_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
  endfunction

  // Same home slot, different key: flip bits above the slot index
  function automatic logic [KEY_W-1:0] alias_key(input logic [KEY_W-1:0] k);
    return k ^ (KEY_W'($urandom_range(1, 32'h07FF_FFFF)) << 4);
  endfunction

  task automatic random_op();
    int               r;
    logic [KEY_W-1:0] key;
    r = $urandom_range(0, 99);
    if (inserted_keys.size() == 0) key = any_key();
    else if (r < 50) key = known_key();
    else if (r < 80) key = alias_key(known_key());
    else key = any_key();
    if ($urandom_range(0, 99) < INSERT_PCT) send_op(FUNC_INSERT, key, $urandom);
    else send_op(FUNC_SEARCH, key, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, wrap-around probe, duplicate, misses
    send_op(FUNC_SEARCH, '0, '0);
    send_op(FUNC_INSERT, '0, 32'h8000_0000);
    send_op(FUNC_INSERT, KEY_MAX, 32'h7FFF_FFFF);
    send_op(FUNC_INSERT, 31'd31, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, '0, 32'h0000_0001);
    send_op(FUNC_SEARCH, '0, 32'hFFFF_FFFF);
    send_op(FUNC_SEARCH, 31'd31, '0);
    send_op(FUNC_SEARCH, KEY_MAX, '0);
    send_op(FUNC_SEARCH, 31'd16, '0);
    send_op(FUNC_SEARCH, 31'h7FFF_FFF0, '0);
    send_op(FUNC_INSERT, 31'h7FFF_FFF0, 32'h5555_5555);
    send_op(FUNC_SEARCH, 31'h7FFF_FFF0, 32'hAAAA_AAAA);
    send_op(FUNC_INSERT, 31'd5, 32'hAAAA_AAAA);
    send_op(FUNC_SEARCH, 31'd5, '0);
    wait_drained();

    // Random: free-running, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 6 : 0;
      rx_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 6 : 0;
      repeat (OPS_PER_PHASE) random_op();
      if (phase == 0 || phase == 2) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d stored, %0d dropped on a full table, %0d found, %0d missed",
             n_stored + n_full + n_found + n_missing, n_stored, n_full, n_found, n_missing);
    $display("Covered wrap-around probing, duplicate and aliased keys, under gaps and stalls");
    if (errors == 0) begin
      $display("[linear_probe_hash_table] OK");
    end else begin
      $display("[linear_probe_hash_table] ERROR");
    end
    $finish;
  end

endmodule
